FILE: design/sdc_pkg.sv
// ----------------------------------------------------------------------------
// sdc_pkg: shared types, constants and functions of the calendar date block
// Holds the Gregorian limits, the command codes, the month-length rule and
// the result record of the shared compare-subtract unit.
// ----------------------------------------------------------------------------
package sdc_pkg;

    localparam logic [11:0] YEAR_FIRST    = 12'd1900;
    localparam logic [11:0] YEAR_LAST     = 12'd2099;
    localparam logic [11:0] YEAR_FALLBACK = 12'd2000;
    localparam logic [16:0] SERIAL_MAX    = 17'd73049;
    localparam int          REM_W         = 17;
    localparam int          LEN_W         = 9;

    typedef enum logic [1:0] {
        FUNC_READ   = 2'd0,
        FUNC_SERIAL = 2'd1,
        FUNC_LOAD   = 2'd2,
        FUNC_KEEP   = 2'd3
    } t_func;

    typedef struct packed {
        logic             fits;  // remainder is at most the length
        logic [REM_W-1:0] diff;  // remainder minus the length
    } t_csub_res;

    // Valid for 1900..2099 only: inside that span the one century year
    // that is not a leap year is 1900.
    function automatic logic is_leap(input logic [11:0] year);
        return (year[1:0] == 2'b00) && (year != YEAR_FIRST);
    endfunction

    function automatic logic [4:0] days_in_month(input logic [11:0] year,
                                                 input logic [3:0]  month);
        logic [4:0] len;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:    len = is_leap(year) ? 5'd29 : 5'd28;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

FILE: design/serial_day_calendar_date.sv
// ----------------------------------------------------------------------------
// serial_day_calendar_date: Gregorian date register for 1900 to 2099
// Keeps one date; reads it, loads it from a serial day number, or loads it
// from checked year, month and day fields.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a clock edge with start high and busy low. Every item
//   gives one result: the stored date after the operation, shown on
//   o_year_out, o_month_out and o_day_out for one cycle with o_valid high.
//   The receiver cannot hold results off.
//   Read and field loads answer in the cycle after the item is taken, and
//   busy stays low, so a new item may follow at once.
//   A serial day load walks one year per cycle from 1900 and then one month
//   per cycle through a single compare-subtract unit. Busy is high from
//   acceptance to the result, and the year walk sets the longest wait.
//   Busy drops in the result cycle, so the next item may be taken there.
//   Reset puts the date at 2000-01-01 with no result pending.
// ----------------------------------------------------------------------------
module serial_day_calendar_date
    import sdc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic [17:0] i_serial_day,
    input  logic [15:0] i_year_in,
    input  logic [7:0]  i_month_in,
    input  logic [7:0]  i_day_in,
    output logic        o_valid,
    output logic [11:0] o_year_out,
    output logic [3:0]  o_month_out,
    output logic [4:0]  o_day_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_YEAR,
        S_MONTH
    } t_state;

    t_state           r_state, n_state;
    logic [11:0]      r_year, n_year;
    logic [3:0]       r_month, n_month;
    logic [4:0]       r_day, n_day;
    logic [REM_W-1:0] r_rem, n_rem;
    logic             r_valid, n_valid;

    logic             accept;
    logic [15:0]      req_year;
    logic [7:0]       req_month;
    logic [7:0]       req_day;
    logic [11:0]      chk_year;
    logic [3:0]       chk_month;
    logic [4:0]       chk_day;
    logic [REM_W-1:0] clamp_rem;
    logic [LEN_W-1:0] unit_len;
    t_csub_res        unit_res;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // Field load: with the keep command a zero field takes the stored value.
    always_comb begin
        req_year  = i_year_in;
        req_month = i_month_in;
        req_day   = i_day_in;
        if (t_func'(i_func) == FUNC_KEEP) begin
            if (i_year_in == 16'd0) req_year = {4'd0, r_year};
            if (i_month_in == 8'd0) req_month = {4'd0, r_month};
            if (i_day_in == 8'd0) req_day = {3'd0, r_day};
        end
        if (req_year < {4'd0, YEAR_FIRST} || req_year > {4'd0, YEAR_LAST})
            chk_year = YEAR_FALLBACK;
        else
            chk_year = req_year[11:0];
        if (req_month < 8'd1 || req_month > 8'd12)
            chk_month = 4'd1;
        else
            chk_month = req_month[3:0];
        if (req_day < 8'd1 || req_day > {3'd0, days_in_month(chk_year, chk_month)})
            chk_day = 5'd1;
        else
            chk_day = req_day[4:0];
    end

    always_comb begin
        if ($signed(i_serial_day) < 18'sd1)
            clamp_rem = 17'd1;
        else if ($signed(i_serial_day) > $signed({1'b0, SERIAL_MAX}))
            clamp_rem = SERIAL_MAX;
        else
            clamp_rem = i_serial_day[16:0];
    end

    assign unit_len = (r_state == S_YEAR)
                    ? (is_leap(r_year) ? 9'd366 : 9'd365)
                    : {4'd0, days_in_month(r_year, r_month)};

    sdc_csub u_csub (
        .i_rem (r_rem),
        .i_len (unit_len),
        .o_res (unit_res)
    );

    always_comb begin
        n_state = r_state;
        n_year  = r_year;
        n_month = r_month;
        n_day   = r_day;
        n_rem   = r_rem;
        n_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_func'(i_func))
                        FUNC_READ: begin
                            n_valid = 1'b1;
                        end
                        FUNC_SERIAL: begin
                            n_year  = YEAR_FIRST;
                            n_month = 4'd1;
                            n_rem   = clamp_rem;
                            n_state = S_YEAR;
                        end
                        FUNC_LOAD, FUNC_KEEP: begin
                            n_year  = chk_year;
                            n_month = chk_month;
                            n_day   = chk_day;
                            n_valid = 1'b1;
                        end
                        default: n_valid = 1'b1;
                    endcase
                end
            end
            S_YEAR: begin
                if (unit_res.fits || r_year >= YEAR_LAST) begin
                    n_state = S_MONTH;
                end else begin
                    n_rem  = unit_res.diff;
                    n_year = r_year + 12'd1;
                end
            end
            S_MONTH: begin
                if (unit_res.fits || r_month >= 4'd12) begin
                    n_day   = r_rem[4:0];
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_rem   = unit_res.diff;
                    n_month = r_month + 4'd1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_year  <= YEAR_FALLBACK;
            r_month <= 4'd1;
            r_day   <= 5'd1;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_year  <= n_year;
            r_month <= n_month;
            r_day   <= n_day;
            r_valid <= n_valid;
        end
        r_rem <= n_rem;
    end

    assign o_valid     = r_valid;
    assign o_year_out  = r_year;
    assign o_month_out = r_month;
    assign o_day_out   = r_day;

    a_no_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_valid)
        else $error("result strobe raised during a serial conversion");

    a_result_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_year_out >= YEAR_FIRST) && (o_year_out <= YEAR_LAST)
                    && (o_month_out >= 4'd1) && (o_month_out <= 4'd12)
                    && (o_day_out >= 5'd1)
                    && (o_day_out <= days_in_month(o_year_out, o_month_out)))
        else $error("result date is not a valid calendar date");

    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (t_func'(i_func) != FUNC_SERIAL)) |=> (o_valid && !busy))
        else $error("read or field load did not answer in the next cycle");

    a_serial_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (t_func'(i_func) == FUNC_SERIAL)) |=> (r_state == S_YEAR))
        else $error("serial load did not start the year walk");

    a_month_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MONTH) |-> (r_year <= YEAR_LAST) && (r_month >= 4'd1)
                                 && (r_month <= 4'd12))
        else $error("month walk left the calendar range");

endmodule

FILE: design/sdc_csub.sv
// ----------------------------------------------------------------------------
// sdc_csub: shared compare-subtract unit
// Compares the running day remainder with a year or month length and gives
// the remainder with that length removed.
// ----------------------------------------------------------------------------
module sdc_csub
    import sdc_pkg::*;
(
    input  logic [REM_W-1:0] i_rem,
    input  logic [LEN_W-1:0] i_len,
    output t_csub_res        o_res
);

    logic [REM_W-1:0] len_ext;

    assign len_ext     = {{(REM_W-LEN_W){1'b0}}, i_len};
    assign o_res.fits  = (i_rem <= len_ext);
    assign o_res.diff  = i_rem - len_ext;

endmodule
